/* rtl/bpc_pkg.sv */
// Shared types, codes and constants for the barometric pressure compensation block.
package bpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AC1     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC2     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC3     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC4     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B1      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_B2      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_TEMP = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam int P_MAX   = 262143;
    localparam int P_CLAMP = 1048576;

    typedef struct packed {
        logic        new_temp;
        logic [15:0] raw_temp;
        logic [23:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic [17:0]        pressure_pa;
        logic [1:0]         status;
    } out_item_t;

    // Compensation steps, each one multiply or divide on the shared unit
    typedef enum logic [3:0] {
        STEP_T_X1,
        STEP_T_DIV,
        STEP_T_SQ,
        STEP_T_B2,
        STEP_T_B3,
        STEP_T_AC3,
        STEP_T_B1,
        STEP_T_B4,
        STEP_P_B7,
        STEP_P_DIV,
        STEP_P_SQ,
        STEP_P_X1,
        STEP_P_X2
    } step_t;

    typedef struct packed {
        logic  capture;
        logic  load;
        logic  commit;
        logic  no_temp;
        logic  emit;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic new_temp;
        logic temp_seen;
        logic press_done;
    } dp_stat_t;

endpackage

/* rtl/bpc_dp.sv */
// Datapath: coefficients, kept terms and a shared shift-add multiply / restoring divide unit.
module bpc_dp #(
    parameter int OVERSAMPLING = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  bpc_pkg::in_item_t              in_item,
    input  bpc_pkg::dp_cmd_t               cmd,
    output bpc_pkg::dp_stat_t              stat,
    output bpc_pkg::out_item_t             out_item
);
    import bpc_pkg::*;

    localparam int OSS     = OVERSAMPLING;
    localparam int B7_MUL  = 50000 >> OSS;
    localparam int T_DIV_N = 27;
    localparam int P_DIV_N = 22;

    // coefficients
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, b1_reg, b2_reg;
    logic [31:0] ac56_reg, mcmd_reg;

    // kept state
    logic signed [31:0] b3_reg;
    logic [31:0]        b4_reg;
    logic signed [15:0] held_temp_reg;
    logic               temp_seen_reg;

    // item work registers
    in_item_t           in_reg;
    logic signed [19:0] x1_reg;
    logic signed [29:0] b6_reg;
    logic signed [47:0] sq_reg;
    logic signed [63:0] t_reg;
    logic signed [49:0] b7_reg;
    logic               dbl_reg;
    logic [20:0]        p_reg;
    logic [1:0]         st_reg;
    logic               pdone_reg;
    out_item_t          out_reg;

    // shared arithmetic unit
    logic               div_mode_reg;
    logic [5:0]         cnt_reg;
    logic signed [63:0] acc_reg, ma_reg;
    logic [31:0]        mb_reg;
    logic [63:0]        rem_reg, dd_reg;
    logic [27:0]        q_reg;
    logic               qneg_reg;

    logic signed [63:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [63:0]        ac4, ac5, ac6;

    // load operand selection
    logic signed [63:0] mul_a;
    logic signed [31:0] mul_b;
    logic [5:0]         ld_n;
    logic               ld_div;
    logic [63:0]        div_num, div_dd;
    logic               div_force, div_qneg, div_dbl;
    logic [27:0]        div_q0;

    // temporaries
    logic signed [63:0] t_num, t_den, t_num_mag, t_den_mag;
    logic signed [63:0] p_b7;
    logic [63:0]        p_num;
    logic signed [63:0] x2_div, b5, tmp_t, b3_full, x3, t4, pq, pf;
    logic [63:0]        b4_full;

    always_comb
    begin
        ac1 = 64'(signed'(ac1_reg));
        ac2 = 64'(signed'(ac2_reg));
        ac3 = 64'(signed'(ac3_reg));
        b1  = 64'(signed'(b1_reg));
        b2  = 64'(signed'(b2_reg));
        mc  = 64'(signed'(mcmd_reg[31:16]));
        md  = 64'(signed'(mcmd_reg[15:0]));
        ac4 = 64'(ac4_reg);
        ac5 = 64'(ac56_reg[31:16]);
        ac6 = 64'(ac56_reg[15:0]);
    end

    always_comb
    begin
        t_num     = mc <<< 11;
        t_den     = 64'(x1_reg) + md;
        t_num_mag = t_num[63] ? -t_num : t_num;
        t_den_mag = t_den[63] ? -t_den : t_den;
        p_b7      = 64'(b7_reg);
        p_num     = (p_b7 >= 64'sh8000_0000) ? 64'(p_b7) : 64'(p_b7 <<< 1);
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        ld_n      = '0;
        ld_div    = 1'b0;
        div_num   = '0;
        div_dd    = '0;
        div_force = 1'b0;
        div_qneg  = 1'b0;
        div_dbl   = 1'b0;
        div_q0    = '0;
        case (cmd.step)
            STEP_T_X1:
            begin
                mul_a = 64'(in_reg.raw_temp) - ac6;
                mul_b = 32'(ac5);
                ld_n  = 6'd16;
            end
            STEP_T_DIV:
            begin
                ld_div    = 1'b1;
                ld_n      = 6'(T_DIV_N);
                div_num   = 64'(t_num_mag);
                div_dd    = 64'(t_den_mag) << (T_DIV_N - 1);
                div_force = (t_den == 64'sd0);
                div_qneg  = t_num[63] ^ t_den[63];
            end
            STEP_T_SQ:
            begin
                mul_a = 64'(b6_reg);
                mul_b = 32'(b6_reg);
                ld_n  = 6'd30;
            end
            STEP_T_B2:
            begin
                mul_a = 64'(sq_reg);
                mul_b = 32'(b2);
                ld_n  = 6'd16;
            end
            STEP_T_B3:
            begin
                mul_a = 64'(b6_reg);
                mul_b = 32'(ac2);
                ld_n  = 6'd16;
            end
            STEP_T_AC3:
            begin
                mul_a = 64'(b6_reg);
                mul_b = 32'(ac3);
                ld_n  = 6'd16;
            end
            STEP_T_B1:
            begin
                mul_a = 64'(sq_reg);
                mul_b = 32'(b1);
                ld_n  = 6'd16;
            end
            STEP_T_B4:
            begin
                mul_a = t_reg;
                mul_b = 32'(ac4);
                ld_n  = 6'd16;
            end
            STEP_P_B7:
            begin
                mul_a = 64'(in_reg.raw_pressure) - 64'(b3_reg);
                mul_b = 32'(B7_MUL);
                ld_n  = 6'd16;
            end
            STEP_P_DIV:
            begin
                ld_div    = 1'b1;
                ld_n      = 6'(P_DIV_N);
                div_num   = p_num;
                div_dd    = 64'(b4_reg) << (P_DIV_N - 1);
                div_dbl   = (p_b7 >= 64'sh8000_0000);
                // quotient would pass 2^22: saturate, clamped later anyway
                div_force = ((p_num >> P_DIV_N) >= 64'(b4_reg));
                div_q0    = div_force ? 28'(1 << P_DIV_N) : '0;
            end
            STEP_P_SQ:
            begin
                mul_a = 64'(p_reg >> 8);
                mul_b = 32'(p_reg >> 8);
                ld_n  = 6'd13;
            end
            STEP_P_X1:
            begin
                mul_a = t_reg;
                mul_b = 32'sd3038;
                ld_n  = 6'd12;
            end
            STEP_P_X2:
            begin
                mul_a = 64'(p_reg);
                mul_b = -32'sd7357;
                ld_n  = 6'd13;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // commit-side arithmetic
    always_comb
    begin
        x2_div  = qneg_reg ? -$signed(64'(q_reg)) : $signed(64'(q_reg));
        b5      = 64'(x1_reg) + x2_div;
        tmp_t   = (b5 + 64'sd8) >>> 4;
        x3      = t_reg + (acc_reg >>> 11);
        b3_full = (((ac1 <<< 2) + x3) <<< OSS) + 64'sd2;
        b3_full = b3_full >>> 2;
        t4      = ((t_reg + (acc_reg >>> 16) + 64'sd2) >>> 2) + 64'sd32768;
        b4_full = 64'(acc_reg >>> 15);
        pq      = dbl_reg ? $signed(64'(q_reg) << 1) : $signed(64'(q_reg));
        pf      = $signed(64'(p_reg))
                  + ((t_reg + (acc_reg >>> 16) + 64'sd3791) >>> 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg       <= '0;
            ac2_reg       <= '0;
            ac3_reg       <= '0;
            ac4_reg       <= '0;
            ac56_reg      <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            mcmd_reg      <= '0;
            b3_reg        <= '0;
            b4_reg        <= '0;
            held_temp_reg <= '0;
            temp_seen_reg <= 1'b0;
            cnt_reg       <= '0;
            div_mode_reg  <= 1'b0;
            pdone_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_AC1:     ac1_reg  <= cfg_data[15:0];
                    REG_AC2:     ac2_reg  <= cfg_data[15:0];
                    REG_AC3:     ac3_reg  <= cfg_data[15:0];
                    REG_AC4:     ac4_reg  <= cfg_data[15:0];
                    REG_AC5_AC6: ac56_reg <= cfg_data;
                    REG_B1:      b1_reg   <= cfg_data[15:0];
                    REG_B2:      b2_reg   <= cfg_data[15:0];
                    REG_MC_MD:   mcmd_reg <= cfg_data;
                    default:     ac1_reg  <= ac1_reg;
                endcase
            end

            if (cmd.load)
            begin
                div_mode_reg <= ld_div;
                cnt_reg      <= (ld_div && div_force) ? '0 : ld_n;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end

            if (cmd.commit)
            begin
                case (cmd.step)
                    STEP_T_DIV:
                    begin
                        if (tmp_t > 64'sd32767)
                            held_temp_reg <= 16'sh7FFF;
                        else if (tmp_t < -64'sd32768)
                            held_temp_reg <= 16'sh8000;
                        else
                            held_temp_reg <= 16'(tmp_t);
                    end
                    STEP_T_B3:
                    begin
                        if (b3_full > 64'sh7FFF_FFFF)
                            b3_reg <= 32'sh7FFF_FFFF;
                        else if (b3_full < -64'sh8000_0000)
                            b3_reg <= 32'sh8000_0000;
                        else
                            b3_reg <= 32'(b3_full);
                    end
                    STEP_T_B4:
                    begin
                        b4_reg        <= (b4_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : b4_full[31:0];
                        temp_seen_reg <= 1'b1;
                    end
                    STEP_P_B7:
                    begin
                        pdone_reg <= acc_reg[63] || (b4_reg == '0);
                    end
                    default:
                    begin
                        pdone_reg <= pdone_reg;
                    end
                endcase
            end
        end
    end

    // payload and work registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_item;

        if (cmd.load)
        begin
            acc_reg  <= '0;
            ma_reg   <= mul_b[31] ? -mul_a : mul_a;
            mb_reg   <= mul_b[31] ? 32'(-mul_b) : 32'(mul_b);
            rem_reg  <= div_num;
            dd_reg   <= div_dd;
            q_reg    <= div_q0;
            qneg_reg <= div_qneg;
            if (ld_div)
                dbl_reg <= div_dbl;
        end
        else if (cnt_reg != '0)
        begin
            if (div_mode_reg)
            begin
                if (rem_reg >= dd_reg)
                begin
                    rem_reg <= rem_reg - dd_reg;
                    q_reg   <= {q_reg[26:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[26:0], 1'b0};
                end
                dd_reg <= dd_reg >> 1;
            end
            else
            begin
                if (mb_reg[0])
                    acc_reg <= acc_reg + ma_reg;
                ma_reg <= ma_reg <<< 1;
                mb_reg <= mb_reg >> 1;
            end
        end

        if (cmd.commit)
        begin
            case (cmd.step)
                STEP_T_X1:  x1_reg <= 20'(acc_reg >>> 15);
                STEP_T_DIV: b6_reg <= 30'(b5 - 64'sd4000);
                STEP_T_SQ:  sq_reg <= 48'(acc_reg >>> 12);
                STEP_T_B2:  t_reg  <= acc_reg >>> 11;
                STEP_T_AC3: t_reg  <= acc_reg >>> 13;
                STEP_T_B1:  t_reg  <= t4[63] ? 64'sd0 : t4;
                STEP_P_B7:
                begin
                    b7_reg <= 50'(acc_reg);
                    if (acc_reg[63])
                    begin
                        p_reg  <= '0;
                        st_reg <= ST_SAT;
                    end
                    else if (b4_reg == '0)
                    begin
                        p_reg  <= 21'(P_MAX);
                        st_reg <= ST_SAT;
                    end
                    else
                    begin
                        st_reg <= ST_OK;
                    end
                end
                STEP_P_DIV:
                begin
                    p_reg <= (pq > 64'(P_CLAMP)) ? 21'(P_CLAMP) : 21'(pq);
                end
                STEP_P_SQ: t_reg <= acc_reg;
                STEP_P_X1: t_reg <= acc_reg >>> 16;
                STEP_P_X2:
                begin
                    if (pf < 64'sd0)
                    begin
                        p_reg  <= '0;
                        st_reg <= ST_SAT;
                    end
                    else if (pf > 64'(P_MAX))
                    begin
                        p_reg  <= 21'(P_MAX);
                        st_reg <= ST_SAT;
                    end
                    else
                    begin
                        p_reg <= 21'(pf);
                    end
                end
                default:
                begin
                    t_reg <= t_reg;
                end
            endcase
        end

        if (cmd.no_temp)
        begin
            p_reg  <= '0;
            st_reg <= ST_NO_TEMP;
        end

        if (cmd.emit)
        begin
            out_reg.temp_tenths <= held_temp_reg;
            out_reg.pressure_pa <= p_reg[17:0];
            out_reg.status      <= st_reg;
        end
    end

    assign stat.busy       = (cnt_reg != '0);
    assign stat.new_temp   = in_reg.new_temp;
    assign stat.temp_seen  = temp_seen_reg;
    assign stat.press_done = pdone_reg;
    assign out_item        = out_reg;

endmodule

/* rtl/bpc_ctrl.sv */
// Controller: sequences the compensation steps and owns the item handshakes.
module bpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bpc_pkg::dp_stat_t stat,
    output bpc_pkg::dp_cmd_t  cmd
);
    import bpc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_RUN,
        S_NEXT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.step       = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.new_temp)
                begin
                    step_next  = STEP_T_X1;
                    state_next = S_LOAD;
                end
                else if (stat.temp_seen)
                begin
                    step_next  = STEP_P_B7;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.no_temp = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (!stat.busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                state_next = S_LOAD;
                unique case (step_reg)
                    STEP_T_X1:  step_next = STEP_T_DIV;
                    STEP_T_DIV: step_next = STEP_T_SQ;
                    STEP_T_SQ:  step_next = STEP_T_B2;
                    STEP_T_B2:  step_next = STEP_T_B3;
                    STEP_T_B3:  step_next = STEP_T_AC3;
                    STEP_T_AC3: step_next = STEP_T_B1;
                    STEP_T_B1:  step_next = STEP_T_B4;
                    STEP_T_B4:  step_next = STEP_P_B7;
                    STEP_P_B7:
                    begin
                        step_next = STEP_P_DIV;
                        if (stat.press_done)
                            state_next = S_DONE;
                    end
                    STEP_P_DIV: step_next = STEP_P_SQ;
                    STEP_P_SQ:  step_next = STEP_P_X1;
                    STEP_P_X1:  step_next = STEP_P_X2;
                    default:    state_next = S_DONE;
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_T_X1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/baro_pressure_compensation.sv */
// Top level of the barometric temperature / pressure compensation block.
// Work per item: a pressure-only item runs the pressure steps, cut short after
//   B7 when B7 is negative or B4 is zero, none before any temperature; new_temp
//   also recomputes temperature, B3 and B4; steps run on the shared shift-add
//   multiplier (one bit a cycle) and restoring divider (one quotient bit a cycle).
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: asynchronous active low; coefficients, B3, B4, temperature and the
//   temperature-seen flag clear, no clearing pass.
module baro_pressure_compensation #(
    parameter int OVERSAMPLING = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
    // raw sample items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bpc_pkg::in_item_t              in_item,
    // compensated result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output bpc_pkg::out_item_t             out_item
);
    import bpc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller walks the datasheet steps: on a temperature update
    // x1, x2 (divide), b6^2, then the B3 and B4 terms; then b7, and
    // unless B7 < 0 or B4 = 0, the b7/B4 divide and correction polynomial.
    bpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath holds the coefficients, kept terms, the arithmetic unit
    // and the output register that decouples the result side.
    bpc_dp #(
        .OVERSAMPLING (OVERSAMPLING)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_item)
    );

endmodule

/* rtl/bpc_checker.sv */
// Port-level checker for the compensation block, bound to the top level.
module bpc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input bpc_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_ready,
    input bpc_pkg::out_item_t out_item
);
    import bpc_pkg::*;

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    a_no_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_NO_TEMP |-> out_item.pressure_pa == '0)
        else $error("no-temperature result carries a pressure");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status == ST_OK || out_item.status == ST_NO_TEMP
                      || out_item.status == ST_SAT)
        else $error("undefined status code");

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (.*);
